### src/rbf_pkg.sv
// Package for the Gaussian radial-basis network evaluator.
// Holds sizes, operation codes, state encoding and the exp(-t) table function.
// No dependencies.
package rbf_pkg;

  localparam int MAX_CENTERS     = 16;
  localparam int MAX_DIMS        = 8;
  localparam int EXP_TABLE_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_CENTER = 2'd1,
    OP_SAMPLE      = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_NUM_CENTERS = 2'd0,
    REG_NUM_DIMS    = 2'd1,
    REG_GAMMA       = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_SCALE,
    ST_TERM,
    ST_ACC,
    ST_DONE
  } state_t;

  localparam logic [31:0] STEP_FACTOR = 32'd4034748382;

  // Entry i approximates exp(-i/16) in Q0.16; evaluated at elaboration.
  function automatic logic [15:0] exp_entry(input int unsigned i);
    logic [63:0]  e;
    logic [127:0] p;
    logic [63:0]  q;
    e = 64'h1_0000_0000;
    for (int unsigned k = 0; k < i; k++) begin
      p = e * STEP_FACTOR + (128'd1 << 31);
      e = p[95:32];
    end
    q = (e + 64'd32768) >> 16;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

endpackage

### src/rbf_network_evaluate.sv
// Top level of the Gaussian radial-basis network evaluator.
// Depends on rbf_pkg for sizes, codes, state type and the exp table function.
//
// A load item is stored when it is accepted and does not start an evaluation. A sample
// item for the last used dimension starts one: a shared multiplier works through each
// coordinate (difference, square) and then each center (scale by gamma, table lookup,
// weighted accumulate). The center and dimension counts are the effective values when the
// item is accepted; gamma is read during the evaluation. busy is high meanwhile.
// The result appears for one cycle on out_valid and must be taken then.
module rbf_network_evaluate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_center_index,
  input  logic [2:0]         in_dim_index,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_response,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int MAX_CENTERS     = rbf_pkg::MAX_CENTERS;
  localparam int MAX_DIMS        = rbf_pkg::MAX_DIMS;
  localparam int EXP_TABLE_DEPTH = rbf_pkg::EXP_TABLE_DEPTH;
  localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TW = $clog2(EXP_TABLE_DEPTH);
  localparam int MEM_DEPTH = MAX_CENTERS * MAX_DIMS;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int L2W = 32 + 4;

  logic [4:0]  num_centers_r;
  logic [3:0]  num_dims_r;
  logic [15:0] gamma_r;

  logic signed [15:0] weight_mem [MAX_CENTERS];
  logic signed [15:0] center_mem [MEM_DEPTH];
  logic signed [15:0] sample_r [MAX_DIMS];

  rbf_pkg::state_t state_r, state_nxt;
  logic [CW:0]  cent_r, cent_nxt;
  logic [DW:0]  dim_r, dim_nxt;
  logic [CW:0]  ncent_r;
  logic [DW:0]  ndim_r;
  logic signed [15:0] center_rd_r;
  logic signed [15:0] weight_rd_r;
  logic signed [16:0] diff_r;
  logic [L2W-1:0]     l2_r;
  logic [TW-1:0]      tidx_r;
  logic [15:0]        expv_r;
  logic signed [47:0] acc_r;
  logic               out_valid_r;
  logic signed [31:0] resp_r;
  logic               sat_r;

  logic [15:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = rbf_pkg::exp_entry(g);
  end

  logic [3:0]  eff_dims;
  logic [4:0]  eff_cents;
  logic        accept;
  rbf_pkg::op_t op;
  always_comb begin
    eff_dims = (num_dims_r == 4'd0) ? 4'd1 : num_dims_r;
    if (32'(eff_dims) > MAX_DIMS) eff_dims = 4'(MAX_DIMS);
    eff_cents = (32'(num_centers_r) > MAX_CENTERS) ? 5'(MAX_CENTERS) : num_centers_r;
    op = rbf_pkg::op_t'(in_operation);
    accept = start && !busy;
  end

  logic trigger;
  assign trigger = accept && op == rbf_pkg::OP_SAMPLE && 32'(in_dim_index) < MAX_DIMS
                   && 4'(in_dim_index) == eff_dims - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_centers_r <= 5'd16;
      num_dims_r    <= 4'd8;
      gamma_r       <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbf_pkg::REG_NUM_CENTERS: num_centers_r <= cfg_data[4:0];
        rbf_pkg::REG_NUM_DIMS:    num_dims_r    <= cfg_data[3:0];
        rbf_pkg::REG_GAMMA:       gamma_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stores, written by load and sample items, read during evaluation.
  // The center read is addressed from the next-state counters so its registered data is ready in ST_DIFF.
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = AW'(32'(in_center_index) * MAX_DIMS + 32'(in_dim_index));
  assign rd_addr = AW'(32'(cent_nxt[CW-1:0]) * MAX_DIMS + 32'(dim_nxt[DW-1:0]));

  always_ff @(posedge clk) begin
    if (accept && op == rbf_pkg::OP_LOAD_WEIGHT && 32'(in_center_index) < MAX_CENTERS)
      weight_mem[in_center_index[CW-1:0]] <= in_value;
    if (accept && op == rbf_pkg::OP_LOAD_CENTER && 32'(in_center_index) < MAX_CENTERS
        && 32'(in_dim_index) < MAX_DIMS)
      center_mem[wr_addr] <= in_value;
    if (accept && op == rbf_pkg::OP_SAMPLE && 32'(in_dim_index) < MAX_DIMS)
      sample_r[in_dim_index[DW-1:0]] <= in_value;
    center_rd_r <= center_mem[rd_addr];
    weight_rd_r <= weight_mem[cent_r[CW-1:0]];
  end

  // Shared multiplier: operand selection per state.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    unique case (state_r)
      rbf_pkg::ST_SQUARE: begin
        mul_a = 34'(diff_r);
        mul_b = 34'(diff_r);
      end
      rbf_pkg::ST_SCALE: begin
        mul_a = $signed(34'(l2_r[TW+19:0]));
        mul_b = $signed({18'd0, gamma_r});
      end
      rbf_pkg::ST_ACC: begin
        mul_a = 34'(weight_rd_r);
        mul_b = $signed({18'd0, expv_r});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Only the low bits of l2 go through the multiplier; any higher bit set with a
  // nonzero gamma already puts the index past the end of the table.
  logic          t_clamp;
  logic [TW-1:0] t_idx;
  always_comb begin
    t_clamp = ((gamma_r != 16'd0) && (|l2_r[L2W-1:TW+20])) || (|mul_p[67:TW+20]);
    t_idx = t_clamp ? TW'(EXP_TABLE_DEPTH - 1) : mul_p[TW+19:20];
  end

  always_comb begin
    state_nxt = state_r;
    cent_nxt = cent_r;
    dim_nxt = dim_r;
    unique case (state_r)
      rbf_pkg::ST_IDLE: begin
        if (trigger) begin
          cent_nxt = '0;
          dim_nxt = '0;
          state_nxt = (eff_cents == 5'd0) ? rbf_pkg::ST_DONE : rbf_pkg::ST_DIFF;
        end
      end
      rbf_pkg::ST_DIFF:   state_nxt = rbf_pkg::ST_SQUARE;
      rbf_pkg::ST_SQUARE: begin
        if (dim_r + 1'b1 == ndim_r) begin
          state_nxt = rbf_pkg::ST_SCALE;
        end else begin
          dim_nxt = dim_r + 1'b1;
          state_nxt = rbf_pkg::ST_DIFF;
        end
      end
      rbf_pkg::ST_SCALE: state_nxt = rbf_pkg::ST_TERM;
      rbf_pkg::ST_TERM:  state_nxt = rbf_pkg::ST_ACC;
      rbf_pkg::ST_ACC: begin
        dim_nxt = '0;
        if (cent_r + 1'b1 == ncent_r) begin
          state_nxt = rbf_pkg::ST_DONE;
        end else begin
          cent_nxt = cent_r + 1'b1;
          state_nxt = rbf_pkg::ST_DIFF;
        end
      end
      rbf_pkg::ST_DONE: state_nxt = rbf_pkg::ST_IDLE;
      default: state_nxt = rbf_pkg::ST_IDLE;
    endcase
  end

  logic signed [47:0] rnd;
  logic signed [39:0] rsh;
  always_comb begin
    rnd = acc_r + 48'sd128;
    rsh = 40'(rnd >>> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbf_pkg::ST_IDLE;
      cent_r <= '0;
      dim_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cent_r <= cent_nxt;
      dim_r <= dim_nxt;
      out_valid_r <= (state_r == rbf_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rbf_pkg::ST_IDLE: begin
        ncent_r <= (CW+1)'(eff_cents);
        ndim_r <= (DW+1)'(eff_dims);
        acc_r <= '0;
        l2_r <= '0;
      end
      rbf_pkg::ST_DIFF: diff_r <= 17'(sample_r[dim_r[DW-1:0]]) - 17'(center_rd_r);
      rbf_pkg::ST_SQUARE: l2_r <= l2_r + L2W'(mul_p[33:0]);
      rbf_pkg::ST_SCALE: tidx_r <= t_idx;
      rbf_pkg::ST_TERM: expv_r <= exp_rom[tidx_r];
      rbf_pkg::ST_ACC: begin
        acc_r <= acc_r + 48'(mul_p);
        l2_r <= '0;
      end
      rbf_pkg::ST_DONE: begin
        if (rsh > 40'sd2147483647) begin
          resp_r <= 32'h7FFF_FFFF;
          sat_r <= 1'b1;
        end else if (rsh < -40'sd2147483648) begin
          resp_r <= 32'h8000_0000;
          sat_r <= 1'b1;
        end else begin
          resp_r <= rsh[31:0];
          sat_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_r != rbf_pkg::ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_response = resp_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held more than one cycle");
  a_busy_eval: assert property (@(posedge clk) disable iff (!rst_n)
    trigger |=> busy) else $error("not busy after trigger");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbf_pkg::ST_DONE |=> out_valid) else $error("missing result");
`endif

endmodule

### bench/rbf_network_evaluate_checker.sv
`timescale 1ns / 1ps
// Checker for the radial-basis network evaluator: watches item, result and register ports,
// predicts each response and compares it with what the block returns.
// Depends on rbf_pkg for operation and register codes.
module rbf_network_evaluate_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_center_index,
  input  logic [2:0]         in_dim_index,
  input  logic signed [15:0] in_value,
  input  logic               out_valid,
  input  logic signed [31:0] out_response,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] response;
    logic               saturated;
  } response_t;

  logic [15:0]        gauss_lut [256];
  logic signed [15:0] weights [16];
  logic signed [15:0] centers [128];
  logic signed [15:0] sample [8];
  logic [4:0]         n_centers;
  logic [3:0]         n_dims;
  logic [15:0]        gamma_q;
  response_t          awaited [$];

  initial begin
    logic [63:0]  e;
    logic [127:0] p;
    logic [63:0]  q;
    e = 64'h1_0000_0000;
    for (int i = 0; i < 256; i++) begin
      q = (e + 64'd32768) >> 16;
      gauss_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      p = e * rbf_pkg::STEP_FACTOR + (128'd1 << 31);
      e = p[95:32];
    end
  end

  function automatic int active_dims();
    if (n_dims == 0) return 1;
    if (n_dims > 8) return 8;
    return n_dims;
  endfunction

  function automatic response_t network_response();
    response_t   r;
    int          cents;
    int          dims;
    longint      acc;
    longint      diff;
    longint      rounded;
    longint unsigned l2;
    longint unsigned t;
    longint unsigned idx;
    dims = active_dims();
    cents = (n_centers > 16) ? 16 : n_centers;
    acc = 0;
    for (int c = 0; c < cents; c++) begin
      l2 = 0;
      for (int k = 0; k < dims; k++) begin
        diff = longint'(sample[k]) - longint'(centers[c * 8 + k]);
        l2 += longint'(diff * diff);
      end
      t = longint'(gamma_q) * l2;
      idx = t >> 20;
      if (idx > 255) idx = 255;
      acc += longint'(weights[c]) * longint'({1'b0, gauss_lut[idx]});
    end
    rounded = (acc + 128) >>> 8;
    r.saturated = 1'b0;
    if (rounded > 64'sd2147483647) begin
      rounded = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (rounded < -64'sd2147483648) begin
      rounded = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.response = rounded[31:0];
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      n_centers <= 5'd16;
      n_dims    <= 4'd8;
      gamma_q   <= 16'd256;
    end else begin
      if (cfg_we) begin
        case (rbf_pkg::reg_idx_t'(cfg_index))
          rbf_pkg::REG_NUM_CENTERS: n_centers <= cfg_data[4:0];
          rbf_pkg::REG_NUM_DIMS:    n_dims    <= cfg_data[3:0];
          rbf_pkg::REG_GAMMA:       gamma_q   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (awaited.size() == 0) begin
          report("unexpected result", 0, out_response);
        end else begin
          want = awaited.pop_front();
          if (out_response !== want.response)
            report("response", want.response, out_response);
          if (out_saturated !== want.saturated)
            report("saturated", want.saturated, out_saturated);
        end
      end
      if (start && !busy) begin
        case (rbf_pkg::op_t'(in_operation))
          rbf_pkg::OP_LOAD_WEIGHT: weights[in_center_index] = in_value;
          rbf_pkg::OP_LOAD_CENTER: centers[in_center_index * 8 + in_dim_index] = in_value;
          rbf_pkg::OP_SAMPLE: begin
            sample[in_dim_index] = in_value;
            if (in_dim_index == active_dims() - 1) awaited.push_back(network_response());
          end
          default: ;
        endcase
      end
      pending <= awaited.size();
    end
  end
endmodule

### bench/tb_rbf_network_evaluate.sv
`timescale 1ns / 1ps
// Top of the radial-basis network evaluator testbench: drives items with random gaps and
// register writes, and gives the verdict. Depends on rbf_pkg, the block and its checker.
module tb_rbf_network_evaluate;

  localparam int SETTLE = 340;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_operation;
  logic [3:0]         in_center_index;
  logic [2:0]         in_dim_index;
  logic signed [15:0] in_value;
  logic               out_valid;
  logic signed [31:0] out_response;
  logic               out_saturated;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending;
  int                 used_dims;
  bit                 steady;

  rbf_network_evaluate dut (.*);

  rbf_network_evaluate_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("[rbf_network_evaluate] ERROR");
    $finish;
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic send_item(rbf_pkg::op_t op, int ci, int di, logic [15:0] val);
    int gap;
    gap = 0;
    if (!steady) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3: gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_center_index <= ci[3:0];
    in_dim_index    <= di[2:0];
    in_value        <= val;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(int cents, int dims, int gam);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= rbf_pkg::REG_NUM_CENTERS;
    cfg_data <= 16'(cents);
    @(posedge clk);
    cfg_index <= rbf_pkg::REG_NUM_DIMS;
    cfg_data <= 16'(dims);
    @(posedge clk);
    cfg_index <= rbf_pkg::REG_GAMMA;
    cfg_data <= 16'(gam);
    @(posedge clk);
    cfg_we <= 1'b0;
    used_dims = (dims == 0) ? 1 : (dims > 8 ? 8 : dims);
  endtask

  task automatic random_phase(int count);
    int sent;
    int r;
    sent = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_item(rbf_pkg::OP_LOAD_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 7),
                  pick_value());
        sent++;
      end else if (r < 30) begin
        send_item(rbf_pkg::OP_LOAD_CENTER, $urandom_range(0, 15), $urandom_range(0, 7),
                  pick_value());
        sent++;
      end else if (r < 33) begin
        send_item(rbf_pkg::OP_NONE, $urandom_range(0, 15), $urandom_range(0, 7),
                  pick_value());
      end else if (r < 40) begin
        send_item(rbf_pkg::OP_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 7),
                  pick_value());
        sent++;
      end else begin
        for (int d = 0; d < used_dims; d++)
          send_item(rbf_pkg::OP_SAMPLE, $urandom_range(0, 15), d, pick_value());
        sent += used_dims;
      end
    end
  endtask

  initial begin
    int cfg_list [6][3] = '{'{0, 8, 256}, '{1, 1, 0}, '{31, 15, 65535},
                            '{16, 0, 1}, '{5, 3, 40}, '{16, 8, 256}};
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = rbf_pkg::OP_NONE;
    in_center_index = '0;
    in_dim_index = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_index = rbf_pkg::REG_NUM_CENTERS;
    cfg_data = '0;
    used_dims = 8;
    steady = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every store entry so that no evaluation reads an unwritten one.
    for (int c = 0; c < 16; c++) begin
      send_item(rbf_pkg::OP_LOAD_WEIGHT, c, 0, pick_value());
      for (int d = 0; d < 8; d++) send_item(rbf_pkg::OP_LOAD_CENTER, c, d, pick_value());
    end
    for (int d = 0; d < 8; d++) send_item(rbf_pkg::OP_SAMPLE, 0, d, pick_value());

    send_item(rbf_pkg::OP_NONE, 15, 7, 16'hFFFF);
    send_item(rbf_pkg::OP_LOAD_WEIGHT, 0, 0, 16'h7FFF);
    send_item(rbf_pkg::OP_LOAD_WEIGHT, 15, 0, 16'h8000);
    send_item(rbf_pkg::OP_LOAD_CENTER, 15, 7, 16'h8000);
    for (int d = 0; d < 8; d++)
      send_item(rbf_pkg::OP_SAMPLE, 0, d, (d % 2) ? 16'h7FFF : 16'h8000);
    write_regs(16, 4, 0);
    send_item(rbf_pkg::OP_SAMPLE, 9, 7, 16'h7FFF);
    for (int d = 0; d < 4; d++) send_item(rbf_pkg::OP_SAMPLE, 0, d, 16'h0000);

    steady = 1'b0;
    for (int p = 0; p < 12; p++) begin
      if (p < 6) write_regs(cfg_list[p][0], cfg_list[p][1], cfg_list[p][2]);
      else write_regs($urandom_range(0, 31), $urandom_range(0, 15),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 65535));
      random_phase(70);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("[rbf_network_evaluate] OK");
    end else begin
      $display("[rbf_network_evaluate] ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
src/rbf_pkg.sv
src/rbf_network_evaluate.sv
bench/rbf_network_evaluate_checker.sv
bench/tb_rbf_network_evaluate.sv
